/* sv/gshe_pkg.sv */
// Package for the gray conversion and horizontal Sobel edge block.
// Holds word types, frame limits, gray weights and register indexes.
// No dependencies.
package gshe_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 12;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [23:0] WEIGHT_R = 24'd19589;
    localparam logic [23:0] WEIGHT_G = 24'd38470;
    localparam logic [23:0] WEIGHT_B = 24'd7471;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd1920;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd1080;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RGB    = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_last;
    } t_out_word;

endpackage

/* sv/gray_sobel_horizontal_edge.sv */
// Gray conversion and horizontal Sobel edge filter on a raster pixel stream.
// A result word is registered in stage 1 and then in the output register.
// Throughput: one word per cycle unless o_in_stall; line store ports: one write, two reads.
// Reset: configuration gets its defaults, counters and window are cleared; the line store
// stays undefined until written, with no clearing pass. Depends on gshe_pkg and gshe_ram.
module gray_sobel_horizontal_edge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gshe_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gshe_pkg::t_out_word             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gshe_pkg::APB_AW-1:0]     paddr,
    input  logic [gshe_pkg::APB_DW-1:0]     pwdata,
    output logic [gshe_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import gshe_pkg::*;

    typedef enum logic [1:0] {
        SRC_W5,
        SRC_SOBEL,
        SRC_UPPER,
        SRC_MIDDLE
    } t_src;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic             r_cfg_rgb;

    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic             r_draining, n_draining;

    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic             do_adv;

    logic             accept;
    logic             s1_fire;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] tail_addr;
    logic             s0_res;
    t_src             s0_src;
    logic             s0_last;
    logic [23:0]      gray_sum;
    logic [7:0]       s0_gray;

    logic             r_s1_valid;
    logic             r_s1_pix;
    logic             r_s1_res;
    t_src             r_s1_src;
    logic             r_s1_last;
    logic [7:0]       r_s1_gray;
    logic [COL_W-1:0] r_s1_addr;

    logic             r_fwd_hit;
    logic             r_fwd_tail;
    logic [7:0]       r_fwd_up;
    logic [7:0]       r_fwd_mid;

    logic [7:0]       r_win [9];

    logic [15:0]      line_q, tail_q;
    logic [7:0]       up_q, mid_q, up_eff, mid_eff;
    logic [7:0]       tail_up, tail_mid;
    logic [10:0]      sob_sum, sob_abs;
    logic [7:0]       sob_val;
    logic [7:0]       s1_value;

    logic             r_out_valid;
    t_out_word        r_out_data;

    logic             s1_we;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RESET_WIDTH;
            r_cfg_height <= RESET_HEIGHT;
            r_cfg_rgb    <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WIDTH:  r_cfg_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_cfg_height <= pwdata[CFG_W-1:0];
                REG_RGB:    r_cfg_rgb    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = APB_DW'(r_cfg_width);
            REG_HEIGHT: prdata = APB_DW'(r_cfg_height);
            REG_RGB:    prdata = APB_DW'(r_cfg_rgb);
            default:    prdata = '0;
        endcase
    end

    // effective bounds, minus one
    always_comb begin
        if (r_cfg_width == '0) begin
            w_m1 = '0;
        end else if (r_cfg_width > CFG_W'(MAX_WIDTH)) begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = COL_W'(r_cfg_width - CFG_W'(1));
        end
        if (r_cfg_height == '0) begin
            h_m1 = '0;
        end else if (r_cfg_height > CFG_W'(MAX_HEIGHT)) begin
            h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = ROW_W'(r_cfg_height - CFG_W'(1));
        end
    end

    // handshake
    assign s1_fire    = r_s1_valid && (!r_s1_res || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign accept     = i_in_valid && !o_in_stall;

    // gray conversion
    assign gray_sum = WEIGHT_R * {16'd0, i_in_data.red}
                    + WEIGHT_G * {16'd0, i_in_data.green}
                    + WEIGHT_B * {16'd0, i_in_data.blue};
    assign s0_gray  = r_cfg_rgb ? gray_sum[23:16] : i_in_data.red;

    // position tracking and result decision
    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_draining = r_draining;
        cur_row    = r_out_row;
        cur_col    = r_out_col;
        do_adv     = 1'b0;
        s0_res     = 1'b0;
        s0_src     = SRC_W5;
        s0_last    = 1'b0;
        rd_addr    = r_in_col;
        tail_addr  = w_m1;

        if (accept) begin
            if (i_in_data.req_type == REQ_FLUSH) begin
                tail_addr = r_out_col;
                if (r_draining) begin
                    s0_res = 1'b1;
                    s0_src = (r_out_row >= h_m1) ? SRC_MIDDLE : SRC_UPPER;
                    do_adv = 1'b1;
                end
            end else begin
                if (r_in_row == '0 && r_in_col == '0) begin
                    cur_row    = '0;
                    cur_col    = '0;
                    n_out_row  = '0;
                    n_out_col  = '0;
                    n_draining = 1'b0;
                end
                if (r_in_col == '0 && r_in_row >= ROW_W'(2)) begin
                    s0_res = 1'b1;
                    s0_src = SRC_UPPER;
                    do_adv = 1'b1;
                end
                if (r_in_col != '0 && r_in_row != '0) begin
                    s0_res = 1'b1;
                    do_adv = 1'b1;
                    if (r_in_row == ROW_W'(1) || (r_in_row - ROW_W'(1)) >= h_m1 ||
                        r_in_col == COL_W'(1) || (r_in_col - COL_W'(1)) >= w_m1) begin
                        s0_src = SRC_W5;
                    end else begin
                        s0_src = SRC_SOBEL;
                    end
                end
            end

            if (do_adv) begin
                s0_last = (cur_row >= h_m1) && (cur_col >= w_m1);
                if (cur_col >= w_m1) begin
                    n_out_col = '0;
                    if (cur_row >= h_m1) begin
                        n_out_row  = '0;
                        n_draining = 1'b0;
                    end else begin
                        n_out_row = cur_row + ROW_W'(1);
                    end
                end else begin
                    n_out_col = cur_col + COL_W'(1);
                end
            end

            if (i_in_data.req_type == REQ_PIXEL) begin
                if (r_in_col >= w_m1) begin
                    n_in_col = '0;
                    if (r_in_row >= h_m1) begin
                        n_in_row   = '0;
                        n_draining = 1'b1;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                    end
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_draining <= 1'b0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_draining <= n_draining;
        end
    end

    // line store: upper line in the high byte, middle line in the low byte
    assign s1_we = s1_fire && r_s1_pix;

    gshe_ram #(.DEPTH(MAX_WIDTH), .WIDTH(16)) u_lines (
        .i_clk     (i_clk),
        .i_we      (s1_we),
        .i_waddr   (r_s1_addr),
        .i_wdata   ({mid_eff, r_s1_gray}),
        .i_re      (accept),
        .i_raddr_a (rd_addr),
        .o_rdata_a (line_q),
        .i_raddr_b (tail_addr),
        .o_rdata_b (tail_q)
    );

    assign up_q     = line_q[15:8];
    assign mid_q    = line_q[7:0];
    assign up_eff   = r_fwd_hit  ? r_fwd_up  : up_q;
    assign mid_eff  = r_fwd_hit  ? r_fwd_mid : mid_q;
    assign tail_up  = r_fwd_tail ? r_fwd_up  : tail_q[15:8];
    assign tail_mid = r_fwd_tail ? r_fwd_mid : tail_q[7:0];

    // stage 1 control and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_fwd_tail <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_we && (r_s1_addr == rd_addr);
                r_fwd_tail <= s1_we && (r_s1_addr == tail_addr);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= (i_in_data.req_type == REQ_PIXEL);
            r_s1_res  <= s0_res;
            r_s1_src  <= s0_src;
            r_s1_last <= s0_last;
            r_s1_gray <= s0_gray;
            r_s1_addr <= rd_addr;
            r_fwd_up  <= mid_eff;
            r_fwd_mid <= r_s1_gray;
        end
    end

    // window: rows hold upper, middle, current line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_we) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= up_eff;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid_eff;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_s1_gray;
        end
    end

    // Sobel on the shifted window
    assign sob_sum = {3'b0, r_win[1]} - {3'b0, up_eff}
                   + {2'b0, r_win[4], 1'b0} - {2'b0, mid_eff, 1'b0}
                   + {3'b0, r_win[7]} - {3'b0, r_s1_gray};
    assign sob_abs = sob_sum[10] ? (11'd0 - sob_sum) : sob_sum;
    assign sob_val = (sob_abs > 11'd255) ? 8'd255 : sob_abs[7:0];

    always_comb begin
        case (r_s1_src)
            SRC_W5:     s1_value = r_win[5];
            SRC_SOBEL:  s1_value = sob_val;
            SRC_UPPER:  s1_value = tail_up;
            SRC_MIDDLE: s1_value = tail_mid;
            default:    s1_value = r_win[5];
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_res) begin
            r_out_data.edge_value <= s1_value;
            r_out_data.frame_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* sv/gshe_ram.sv */
// Line store with one write port and two registered read ports.
// Read data holds while no read is issued. No dependencies.
module gshe_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* tb/gray_sobel_horizontal_edge_tb.sv */
// Self-checking testbench for gray_sobel_horizontal_edge: directed and random frames, with
// random idle bursts on both streams, each result word checked against an in-bench prediction.
// Depends on gshe_pkg and the gray_sobel_horizontal_edge RTL.
module gray_sobel_horizontal_edge_tb;
    import gshe_pkg::*;

    localparam int LIMIT = 1_500_000;
    localparam int DRAIN_FULL = 0;
    localparam int DRAIN_PART = 1;
    localparam int DRAIN_OVER = 2;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_word            i_in_data  = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_word           o_out_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    gray_sobel_horizontal_edge uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_in_word  pixel_words[$];
    t_out_word expected_edges[$];
    t_out_word oldest_edge;
    bit        calm = 1'b0;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    int        item_count = 0;

    logic [CFG_W-1:0] cfg_width  = RESET_WIDTH;
    logic [CFG_W-1:0] cfg_height = RESET_HEIGHT;
    logic             cfg_rgb    = 1'b1;

    bit [7:0]       row_above [MAX_WIDTH];
    bit [7:0]       row_mid   [MAX_WIDTH];
    bit [7:0]       win       [9];
    bit [COL_W-1:0] in_col  = '0;
    bit [ROW_W-1:0] in_row  = '0;
    bit [COL_W-1:0] out_col = '0;
    bit [ROW_W-1:0] out_row = '0;
    bit             draining = 1'b0;

    function automatic int clip_dim(input logic [CFG_W-1:0] v, input int max_v);
        if (v == 0)
            return 1;
        return (v > max_v) ? max_v : int'(v);
    endfunction

    function automatic bit next_out_pos(input int w, input int h);
        bit last;
        last = (out_row >= h - 1) && (out_col >= w - 1);
        if (out_col >= w - 1) begin
            out_col = '0;
            if (out_row >= h - 1) begin
                out_row  = '0;
                draining = 1'b0;
            end else begin
                out_row++;
            end
        end else begin
            out_col++;
        end
        return last;
    endfunction

    task automatic predict_edge(input t_in_word word);
        int          w, h, s;
        logic [23:0] wsum;
        bit [7:0]    gray, up, mid;
        bit          border;
        t_out_word   res;
        w = clip_dim(cfg_width, MAX_WIDTH);
        h = clip_dim(cfg_height, MAX_HEIGHT);
        if (word.req_type == REQ_FLUSH) begin
            if (draining) begin
                res.edge_value = (out_row >= h - 1) ? row_mid[out_col] : row_above[out_col];
                res.frame_last = next_out_pos(w, h);
                expected_edges.push_back(res);
            end
        end else begin
            if (cfg_rgb) begin
                wsum = WEIGHT_R * word.red + WEIGHT_G * word.green + WEIGHT_B * word.blue;
                gray = wsum[23:16];
            end else begin
                gray = word.red;
            end
            if (in_row == 0 && in_col == 0) begin
                out_row  = '0;
                out_col  = '0;
                draining = 1'b0;
            end
            up  = row_above[in_col];
            mid = row_mid[in_col];
            if (in_col == 0 && in_row >= 2) begin
                res.edge_value = row_above[w - 1];
                res.frame_last = next_out_pos(w, h);
                expected_edges.push_back(res);
            end
            win[0] = win[1]; win[1] = win[2]; win[2] = up;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid;
            win[6] = win[7]; win[7] = win[8]; win[8] = gray;
            row_above[in_col] = mid;
            row_mid[in_col]   = gray;
            if (in_col >= 1 && in_row >= 1) begin
                border = (in_row == 1) || (in_row - 1 >= h - 1) ||
                         (in_col == 1) || (in_col - 1 >= w - 1);
                s = (int'(win[0]) - int'(win[2])) + 2 * (int'(win[3]) - int'(win[5]))
                  + (int'(win[6]) - int'(win[8]));
                if (s < 0)
                    s = -s;
                if (s > 255)
                    s = 255;
                res.edge_value = border ? win[4] : 8'(s);
                res.frame_last = next_out_pos(w, h);
                expected_edges.push_back(res);
            end
            if (in_col >= w - 1) begin
                in_col = '0;
                if (in_row >= h - 1) begin
                    in_row   = '0;
                    draining = 1'b1;
                end else begin
                    in_row++;
                end
            end else begin
                in_col++;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // input driver: hold a stalled word, otherwise idle in bursts or send the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_edge(i_in_data);
            if (i_in_valid && o_in_stall) begin
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pixel_words.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 9);
                i_in_valid <= 1'b0;
            end else if (pixel_words.size() > 0) begin
                i_in_data  <= pixel_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_edges.size() == 0) begin
                    fail_count++;
                    if (fail_count < 200)
                        $error("unexpected result word: edge_value %0d, frame_last %0d",
                               o_out_data.edge_value, o_out_data.frame_last);
                end else begin
                    oldest_edge = expected_edges.pop_front();
                    if (o_out_data.edge_value !== oldest_edge.edge_value) begin
                        fail_count++;
                        if (fail_count < 200)
                            $error("edge_value mismatch: expected %0d, actual %0d",
                                   oldest_edge.edge_value, o_out_data.edge_value);
                    end
                    if (o_out_data.frame_last !== oldest_edge.frame_last) begin
                        fail_count++;
                        if (fail_count < 200)
                            $error("frame_last mismatch: expected %0d, actual %0d",
                                   oldest_edge.frame_last, o_out_data.frame_last);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        while (pixel_words.size() != 0 || i_in_valid || expected_edges.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW - CFG_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = value;
            REG_HEIGHT: cfg_height = value;
            REG_RGB:    cfg_rgb    = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int w, input int h, input bit rgb);
        wait_idle();
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_RGB, CFG_W'(rgb));
    endtask

    function automatic logic [7:0] rand_channel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_in_word word;
        word.req_type = REQ_PIXEL;
        word.red      = r;
        word.green    = g;
        word.blue     = b;
        pixel_words.push_back(word);
        item_count++;
    endtask

    task automatic push_flush(input int n, input bit counted);
        t_in_word word;
        for (int k = 0; k < n; k++) begin
            word.req_type = REQ_FLUSH;
            word.red      = 8'($urandom);
            word.green    = 8'($urandom);
            word.blue     = 8'($urandom);
            pixel_words.push_back(word);
            if (counted)
                item_count++;
        end
    endtask

    task automatic push_frame(input int drain_mode);
        int w, h, n_px, n_flush;
        w = clip_dim(cfg_width, MAX_WIDTH);
        h = clip_dim(cfg_height, MAX_HEIGHT);
        n_px = w * h;
        n_flush = n_px - (w - 1) * (h - 1) - ((h > 2) ? h - 2 : 0);
        for (int k = 0; k < n_px; k++) begin
            push_pixel(rand_channel(), rand_channel(), rand_channel());
            if (k < n_px - 1 && $urandom_range(0, 19) == 0)
                push_flush(1, 1'b0);
        end
        case (drain_mode)
            DRAIN_PART: push_flush($urandom_range(0, n_flush - 1), 1'b1);
            DRAIN_OVER: begin
                push_flush(n_flush, 1'b1);
                push_flush($urandom_range(1, 3), 1'b0);
            end
            default: push_flush(n_flush, 1'b1);
        endcase
    endtask

    task automatic random_config();
        int w, h;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = $urandom_range(9, 40);
            default: w = $urandom_range(1, 7);
        endcase
        h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        set_config(w, h, $urandom_range(0, 1));
    endtask

    function automatic int random_drain();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return DRAIN_FULL;
        return (r < 17) ? DRAIN_PART : DRAIN_OVER;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // flush with nothing pending, then a single-pixel frame
        push_flush(1, 1'b0);
        set_config(1, 1, 1'b1);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_flush(1, 1'b1);

        // strong positive gradient, then cut the drain short
        set_config(3, 3, 1'b1);
        for (int k = 0; k < 9; k++) begin
            if (k % 3 == 0)
                push_pixel(8'hFF, 8'hFF, 8'hFF);
            else
                push_pixel(8'h00, 8'h00, 8'h00);
        end
        push_flush(3, 1'b1);

        // mono frame with negative gradient, switched to color mid-frame
        wait_idle();
        write_reg(REG_RGB, CFG_W'(0));
        for (int k = 0; k < 9; k++) begin
            if (k == 5) begin
                wait_idle();
                write_reg(REG_RGB, CFG_W'(1));
            end
            case (k % 3)
                0:       push_pixel(8'h00, rand_channel(), rand_channel());
                1:       push_pixel(8'($urandom), rand_channel(), rand_channel());
                default: push_pixel(8'hFF, rand_channel(), rand_channel());
            endcase
        end
        push_flush(4, 1'b1);
        push_flush(1, 1'b0);

        random_config();
        while (item_count < 650) begin
            if ($urandom_range(0, 2) == 0)
                random_config();
            push_frame(random_drain());
        end
        calm = 1'b1;
        while (item_count < 750) begin
            if ($urandom_range(0, 2) == 0)
                random_config();
            push_frame(DRAIN_FULL);
        end

        while (pixel_words.size() != 0 || i_in_valid || expected_edges.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
